/* hw/rtl/sli_pkg.sv */
// Shared types, codes and helpers of the source line index.
`timescale 1ns / 1ps

package sli_pkg;

    // Default store sizes
    localparam int SLI_MAX_BYTES = 4096;
    localparam int SLI_MAX_LINES = 1024;

    // Request opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BYTES_FULL = 2'd1;
    localparam logic [1:0] ST_LINES_FULL = 2'd2;
    localparam logic [1:0] ST_NO_LINE    = 2'd3;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  byte_in;
        logic [11:0] position;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  row;
        logic [11:0] column;
        logic [11:0] line_start;
        logic [12:0] trimmed_len;
        logic [12:0] indent;
    } t_rsp;

    // Map line ends to zero and horizontal/vertical tabs to a space
    function automatic logic [7:0] normalize_byte(input logic [7:0] b);
        logic [7:0] v;
        case (b) inside
            CH_LF, CH_CR:  v = CH_NUL;
            CH_TAB, CH_VT: v = CH_SPACE;
            default:       v = b;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/sli_ifs.sv */
// Request and response channel interfaces of the source line index.
`timescale 1ns / 1ps

interface sli_in_if import sli_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sli_out_if import sli_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sli_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module sli_ram import sli_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = SLI_MAX_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry through an output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sli_cmp_unit.sv */
// Shared subtract and compare unit of the query sequencer.
`timescale 1ns / 1ps

module sli_cmp_unit import sli_pkg::*; #(
    parameter int W = 13
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_diff,
    output logic         o_le
);

    // One subtractor serves both the difference and the compare
    logic [W:0] diff_ext;

    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = diff_ext[W-1:0];
    assign o_le     = diff_ext[W] || (diff_ext[W-1:0] == '0);

endmodule

/* hw/rtl/sli_seq.sv */
// Index state, stores and the query sequencer of the source line index.
`timescale 1ns / 1ps

module sli_seq import sli_pkg::*; #(
    parameter int MAX_BYTES = SLI_MAX_BYTES,
    parameter int MAX_LINES = SLI_MAX_LINES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_rsp_valid,
    output t_rsp o_rsp
);

    localparam int BCW = $clog2(MAX_BYTES + 1);   // byte count / offsets
    localparam int AW  = $clog2(MAX_BYTES);       // text address
    localparam int LW  = $clog2(MAX_LINES);       // line index / line count
    localparam int TW  = LW + 1;                  // row count incl. open line
    localparam int VW  = (BCW > 13) ? BCW : 13;   // compare width

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_SRCH_CHK = 11'b00000000010,
        S_SRCH_CMP = 11'b00000000100,
        S_TRIM_CHK = 11'b00000001000,
        S_TRIM_TST = 11'b00000010000,
        S_IND_CHK  = 11'b00000100000,
        S_IND_TST  = 11'b00001000000,
        S_CLAMP    = 11'b00010000000,
        S_COL      = 11'b00100000000,
        S_LEN      = 11'b01000000000,
        S_IND      = 11'b10000000000
    } t_state;

    // Control state
    t_state         r_state,      n_state;
    logic [BCW-1:0] r_byte_count, n_byte_count;
    logic [LW-1:0]  r_line_count, n_line_count;
    logic [BCW-1:0] r_open,       n_open;

    // Query working registers
    logic [11:0]    r_pos,      n_pos;
    logic [TW-1:0]  r_lo,       n_lo;
    logic [TW-1:0]  r_hi,       n_hi;
    logic [TW-1:0]  r_mid,      n_mid;
    logic           r_use_open, n_use_open;
    logic [VW-1:0]  r_start,    n_start;
    logic [VW-1:0]  r_stop,     n_stop;
    logic [VW-1:0]  r_sp,       n_sp;
    logic [VW-1:0]  r_p,        n_p;
    logic [VW-1:0]  r_col,      n_col;
    logic [VW-1:0]  r_len,      n_len;
    logic           r_empty,    n_empty;

    // Store ports
    logic           text_we;
    logic [AW-1:0]  text_raddr;
    logic [7:0]     text_rdata;
    logic           line_we;
    logic [BCW-1:0] line_rdata;

    // Shared unit
    logic [VW-1:0]  cu_a, cu_b, cu_diff;
    logic           cu_le;

    logic [TW:0]    mid_sum;
    logic [TW-1:0]  mid;
    logic [TW-1:0]  total;
    logic           has_open;

    sli_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_text (
        .i_clk   (i_clk),
        .i_we    (text_we),
        .i_waddr (AW'(r_byte_count)),
        .i_wdata (normalize_byte(i_req.byte_in)),
        .i_raddr (text_raddr),
        .o_rdata (text_rdata)
    );

    sli_ram #(
        .WIDTH (BCW),
        .DEPTH (MAX_LINES)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_line_count),
        .i_wdata (r_open),
        .i_raddr (mid[LW-1:0]),
        .o_rdata (line_rdata)
    );

    sli_cmp_unit #(
        .W (VW)
    ) u_cmp (
        .i_a    (cu_a),
        .i_b    (cu_b),
        .o_diff (cu_diff),
        .o_le   (cu_le)
    );

    // Search midpoint and row count
    assign mid_sum  = (TW + 1)'(r_lo) + (TW + 1)'(r_hi);
    assign mid      = mid_sum[TW:1];
    assign has_open = (r_byte_count > r_open);
    assign total    = TW'(r_line_count) + TW'(has_open);

    // Text read address: leading-space scan or trailing-zero trim
    assign text_raddr = (r_state == S_IND_CHK) ? AW'(r_sp) : AW'(r_stop - VW'(1));

    assign o_busy = (r_state != S_IDLE);

    // Route operands to the shared unit
    always_comb begin
        unique case (r_state)
            S_SRCH_CMP: begin
                cu_a = r_use_open ? VW'(r_open) : VW'(line_rdata);
                cu_b = VW'(r_pos);
            end
            S_IND_CHK: begin
                cu_a = r_stop;
                cu_b = r_sp;
            end
            S_CLAMP: begin
                cu_a = r_stop;
                cu_b = VW'(r_pos);
            end
            S_COL: begin
                cu_a = r_p;
                cu_b = r_start;
            end
            S_IND: begin
                cu_a = r_sp;
                cu_b = r_start;
            end
            default: begin
                cu_a = r_stop;
                cu_b = r_start;
            end
        endcase
    end

    // Sequence appends, clears and the query steps
    always_comb begin
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_line_count = r_line_count;
        n_open       = r_open;
        n_pos        = r_pos;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_use_open   = r_use_open;
        n_start      = r_start;
        n_stop       = r_stop;
        n_sp         = r_sp;
        n_p          = r_p;
        n_col        = r_col;
        n_len        = r_len;
        n_empty      = r_empty;
        text_we      = 1'b0;
        line_we      = 1'b0;
        o_rsp_valid  = 1'b0;
        o_rsp        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_req.opcode)
                        OP_APPEND: begin
                            o_rsp_valid = 1'b1;
                            if (r_byte_count >= BCW'(MAX_BYTES)) begin
                                o_rsp.status = ST_BYTES_FULL;
                            end else if (i_req.byte_in == CH_LF &&
                                         r_line_count >= LW'(MAX_LINES - 1)) begin
                                o_rsp.status = ST_LINES_FULL;
                            end else begin
                                text_we      = 1'b1;
                                n_byte_count = r_byte_count + BCW'(1);
                                if (i_req.byte_in == CH_LF) begin
                                    line_we      = 1'b1;
                                    n_line_count = r_line_count + LW'(1);
                                    n_open       = r_byte_count + BCW'(1);
                                end
                            end
                        end
                        OP_QUERY: begin
                            if (total == '0) begin
                                o_rsp_valid  = 1'b1;
                                o_rsp.status = ST_NO_LINE;
                            end else begin
                                n_pos   = i_req.position;
                                n_lo    = '0;
                                n_hi    = total;
                                n_start = '0;
                                n_stop  = VW'(r_byte_count);
                                n_state = S_SRCH_CHK;
                            end
                        end
                        OP_CLEAR: begin
                            o_rsp_valid  = 1'b1;
                            n_byte_count = '0;
                            n_line_count = '0;
                            n_open       = '0;
                        end
                        default: begin
                            o_rsp_valid = 1'b1;
                        end
                    endcase
                end
            end
            // Halve the row range, or finish when one row is left
            S_SRCH_CHK: begin
                if (r_hi != r_lo + TW'(1)) begin
                    n_mid      = mid;
                    n_use_open = (mid == TW'(r_line_count));
                    n_state    = S_SRCH_CMP;
                end else begin
                    n_state = S_TRIM_CHK;
                end
            end
            S_SRCH_CMP: begin
                if (cu_le) begin
                    n_lo    = r_mid;
                    n_start = cu_a;
                end else begin
                    n_hi   = r_mid;
                    n_stop = cu_a;
                end
                n_state = S_SRCH_CHK;
            end
            // Drop trailing zero bytes
            S_TRIM_CHK: begin
                if (cu_le) begin
                    n_empty = 1'b1;
                    n_sp    = r_start;
                    n_state = S_IND_CHK;
                end else begin
                    n_state = S_TRIM_TST;
                end
            end
            S_TRIM_TST: begin
                if (text_rdata == CH_NUL) begin
                    n_stop  = r_stop - VW'(1);
                    n_state = S_TRIM_CHK;
                end else begin
                    n_empty = 1'b0;
                    n_sp    = r_start;
                    n_state = S_IND_CHK;
                end
            end
            // Count leading spaces
            S_IND_CHK: begin
                n_state = cu_le ? S_CLAMP : S_IND_TST;
            end
            S_IND_TST: begin
                if (text_rdata == CH_SPACE) begin
                    n_sp    = r_sp + VW'(1);
                    n_state = S_IND_CHK;
                end else begin
                    n_state = S_CLAMP;
                end
            end
            // Clamp the position to the last kept byte
            S_CLAMP: begin
                n_p     = cu_le ? (r_stop - VW'(1)) : VW'(r_pos);
                n_state = S_COL;
            end
            S_COL: begin
                n_col   = r_empty ? '0 : cu_diff;
                n_state = S_LEN;
            end
            S_LEN: begin
                n_len   = cu_diff;
                n_state = S_IND;
            end
            S_IND: begin
                o_rsp_valid       = 1'b1;
                o_rsp.status      = ST_OK;
                o_rsp.row         = 10'(r_lo);
                o_rsp.column      = 12'(r_col);
                o_rsp.line_start  = 12'(r_start);
                o_rsp.trimmed_len = 13'(r_len);
                o_rsp.indent      = 13'(cu_diff);
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_byte_count <= '0;
            r_line_count <= '0;
            r_open       <= '0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_line_count <= n_line_count;
            r_open       <= n_open;
        end
    end

    // Query working registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_use_open <= n_use_open;
        r_start    <= n_start;
        r_stop     <= n_stop;
        r_sp       <= n_sp;
        r_p        <= n_p;
        r_col      <= n_col;
        r_len      <= n_len;
        r_empty    <= n_empty;
    end

endmodule

/* hw/rtl/source_line_index_unit.sv */
// Top level of the source line index: request intake and response register.
//
// Usage: requests arrive on i_req (valid/ready) with an opcode, a raw byte and
// a position; one response beat per request leaves on o_rsp (valid/ready).
// Append, clear, the unused opcode and a query on an empty index answer at once:
// the response is loaded into the output register at the edge that takes the
// request, so such beats can follow back to back at one per cycle while the receiver takes each one.
// A query first runs a binary search that halves the row range until one row is
// left: at most ceil(log2(rows)) halvings, each a check and a compare of a line
// start against the position. It then trims trailing zero bytes from the row,
// counts its leading spaces, and runs the clamp and the column, length and indent
// differences; the response is loaded at the edge that ends the indent step.
// i_req.ready is low during reset, while a query is in progress and while a
// response sits in the output register that the receiver does not take in
// that cycle; a stalled receiver therefore holds the block after one response.
// Reset clears the byte count, the line count and the open-line start and
// empties the output register; the text and line stores keep their contents,
// which are never read before they are written again, so no clearing pass
// runs and requests are taken from the first cycle after reset.
`timescale 1ns / 1ps

module source_line_index_unit import sli_pkg::*; #(
    parameter int MAX_BYTES = SLI_MAX_BYTES,
    parameter int MAX_LINES = SLI_MAX_LINES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sli_in_if.sink      i_req,
    sli_out_if.source   o_rsp
);

    logic r_rsp_valid;
    t_rsp r_rsp;
    logic busy;
    logic start;
    logic seq_rsp_valid;
    t_rsp seq_rsp;

    // Take a beat only out of reset, when idle and the output register can take the result
    assign i_req.ready = i_rst_n && !busy && (!r_rsp_valid || o_rsp.ready);
    assign start       = i_req.valid && i_req.ready;

    sli_seq #(
        .MAX_BYTES (MAX_BYTES),
        .MAX_LINES (MAX_LINES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req.data),
        .o_busy      (busy),
        .o_rsp_valid (seq_rsp_valid),
        .o_rsp       (seq_rsp)
    );

    // Hold the response until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (seq_rsp_valid) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_rsp_valid) begin
            r_rsp <= seq_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule

/* verif/source_line_index_unit_test.sv */
// Self-checking testbench for the source line index: directed and random traffic.
`timescale 1ns / 1ps

module source_line_index_unit_test;

    import sli_pkg::*;

    localparam int         TEXT_DEPTH = SLI_MAX_BYTES;
    localparam int         ROW_DEPTH  = SLI_MAX_LINES;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // Mirror of the text store and line table; predicts one response per request beat
    class line_index_checker;
        logic [7:0]  text_mem [TEXT_DEPTH];
        int unsigned row_starts [ROW_DEPTH];
        int unsigned nbytes;
        int unsigned nlines;
        int unsigned open_start;
        t_rsp        awaited_rsp [$];
        int          errors;

        function int unsigned row_begin(int unsigned k);
            return (k < nlines) ? row_starts[k] : open_start;
        endfunction

        function t_rsp predict_line_result(t_req r);
            t_rsp        o;
            logic [7:0]  v;
            int unsigned rows, sel, start, stop, sp, p;
            o = '0;
            case (r.opcode)
                OP_APPEND: begin
                    if (nbytes >= TEXT_DEPTH) begin
                        o.status = ST_BYTES_FULL;
                    end else if (r.byte_in == CH_LF && nlines >= ROW_DEPTH - 1) begin
                        o.status = ST_LINES_FULL;
                    end else begin
                        // close the open line on a newline, fold tabs and line ends
                        v = r.byte_in;
                        if (r.byte_in == CH_LF) begin
                            row_starts[nlines] = open_start;
                            nlines++;
                            open_start = nbytes + 1;
                            v = CH_NUL;
                        end else if (r.byte_in == CH_CR) begin
                            v = CH_NUL;
                        end else if (r.byte_in == CH_TAB || r.byte_in == CH_VT) begin
                            v = CH_SPACE;
                        end
                        text_mem[nbytes] = v;
                        nbytes++;
                    end
                end
                OP_QUERY: begin
                    rows = nlines + ((nbytes > open_start) ? 1 : 0);
                    if (rows == 0) begin
                        o.status = ST_NO_LINE;
                    end else begin
                        p = r.position;
                        sel = 0;
                        for (int unsigned k = 0; k < rows; k++) begin
                            if (row_begin(k) > p) break;
                            sel = k;
                        end
                        start = row_begin(sel);
                        stop  = (sel + 1 < rows) ? row_begin(sel + 1) : nbytes;
                        // trim trailing zero bytes (folded line ends), then count leading spaces
                        while (stop > start && text_mem[stop - 1] == CH_NUL) stop--;
                        sp = start;
                        while (sp < stop && text_mem[sp] == CH_SPACE) sp++;
                        if (start < stop) begin
                            if (p < start) p = start;
                            if (p >= stop) p = stop - 1;
                        end else begin
                            p = start;
                        end
                        o.status      = ST_OK;
                        o.row         = 10'(sel);
                        o.column      = 12'(p - start);
                        o.line_start  = 12'(start);
                        o.trimmed_len = 13'(stop - start);
                        o.indent      = 13'(sp - start);
                    end
                end
                OP_CLEAR: begin
                    nbytes     = 0;
                    nlines     = 0;
                    open_start = 0;
                end
                default: ;
            endcase
            return o;
        endfunction

        function void note_request(t_req r);
            awaited_rsp.push_back(predict_line_result(r));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (awaited_rsp.size() == 0) begin
                $error("response beat with no request outstanding");
                errors++;
                return;
            end
            want = awaited_rsp.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("row", want.row, got.row);
            compare_field("column", want.column, got.column);
            compare_field("line_start", want.line_start, got.line_start);
            compare_field("trimmed_len", want.trimmed_len, got.trimmed_len);
            compare_field("indent", want.indent, got.indent);
        endfunction

        function int outstanding();
            return awaited_rsp.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sli_in_if  req_if ();
    sli_out_if rsp_if ();

    source_line_index_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    line_index_checker lines = new();
    int src_idle_pct;
    int snk_idle_pct;

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: stall at random, check each response beat
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            lines.check_response(rsp_if.data);
    end

    // Drive one request beat, idling at random before it
    task automatic push_request(input t_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        lines.note_request(r);
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] b, input logic [11:0] pos);
        t_req r;
        r.opcode   = op;
        r.byte_in  = b;
        r.position = pos;
        push_request(r);
    endtask

    // Hold the sender until every outstanding response has come back
    task automatic drain_responses();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (lines.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] text_byte();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) return 8'($urandom_range(33, 126));
        if (pick < 65) return CH_SPACE;
        if (pick < 70) return CH_TAB;
        if (pick < 73) return CH_VT;
        if (pick < 85) return CH_LF;
        if (pick < 90) return CH_CR;
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed text with queries near it; some clears and noise
    function automatic t_req random_request();
        t_req        r;
        int unsigned roll;
        int unsigned span;
        roll       = $urandom_range(99);
        r.byte_in  = 8'($urandom_range(255));
        r.position = 12'($urandom_range(4095));
        if (roll < 70) begin
            r.opcode  = OP_APPEND;
            r.byte_in = text_byte();
        end else if (roll < 92) begin
            r.opcode = OP_QUERY;
            span = lines.nbytes + 8;
            if ($urandom_range(3) != 0)
                r.position = 12'($urandom_range((span > 4095) ? 4095 : span));
        end else if (roll < 94) begin
            r.opcode = OP_CLEAR;
        end else if (roll < 97) begin
            r.opcode = OP_UNUSED;
        end else begin
            r.opcode = OP_APPEND;
        end
        return r;
    endfunction

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        src_idle_pct = 33;
        snk_idle_pct = 48;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty index, unused opcode, folding, empty line, past the text
        send_op(OP_QUERY, 8'h00, 12'd0);
        send_op(OP_UNUSED, 8'hFF, 12'hFFF);
        send_op(OP_APPEND, CH_TAB, 12'd0);
        send_op(OP_APPEND, CH_VT, 12'd0);
        send_op(OP_APPEND, CH_SPACE, 12'd0);
        send_op(OP_APPEND, "x", 12'd0);
        send_op(OP_APPEND, 8'hFF, 12'd0);
        send_op(OP_APPEND, CH_CR, 12'd0);
        send_op(OP_APPEND, CH_LF, 12'd0);
        send_op(OP_APPEND, CH_LF, 12'd0);
        send_op(OP_APPEND, "y", 12'd0);
        send_op(OP_APPEND, CH_NUL, 12'd0);
        send_op(OP_QUERY, 8'h00, 12'd0);
        send_op(OP_QUERY, 8'h00, 12'd2);
        send_op(OP_QUERY, 8'h00, 12'd6);
        send_op(OP_QUERY, 8'h00, 12'd7);
        send_op(OP_QUERY, 8'h00, 12'd8);
        send_op(OP_QUERY, 8'h00, 12'hFFF);
        send_op(OP_CLEAR, 8'h00, 12'd0);
        send_op(OP_QUERY, 8'h00, 12'd0);
        send_op(OP_APPEND, CH_LF, 12'd0);
        send_op(OP_QUERY, 8'h00, 12'd5);
        send_op(OP_CLEAR, 8'h00, 12'd0);

        // Random traffic in three idle regimes, draining between them
        for (int n = 0; n < 500; n++) begin
            if (n == 167) begin
                drain_responses();
                src_idle_pct = 48;
                snk_idle_pct = 33;
            end else if (n == 334) begin
                drain_responses();
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            push_request(random_request());
        end

        // Wrap up: release the request line and let the pipe empty
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (lines.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (lines.errors == 0 && lines.outstanding() == 0) begin
            $display("source_line_index_unit_test OK");
        end else begin
            $display("source_line_index_unit_test NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("source_line_index_unit_test NOT OK");
        $finish;
    end

endmodule

/* source_line_index_unit.f */
hw/rtl/sli_pkg.sv
hw/rtl/sli_ifs.sv
hw/rtl/sli_ram.sv
hw/rtl/sli_cmp_unit.sv
hw/rtl/sli_seq.sv
hw/rtl/source_line_index_unit.sv
verif/source_line_index_unit_test.sv
